>>> rtl/sih_pkg.sv
// Shared types, constants and the hash step for the string intern table.
// No dependencies; every file of the block but sih_ram imports this package.
`default_nettype none

package sih_pkg;

    localparam logic [63:0] HASH_BASIS = 64'hcbf2_9ce4_8422_2325;
    localparam int          ID_W       = 10;
    localparam int          MAX_LEN_W  = 11;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2,
        ST_LONG  = 2'd3
    } status_t;

    // One finished name, handed from the front end to the lookup engine
    typedef struct packed {
        logic [63:0]          hash;
        logic [MAX_LEN_W-1:0] len;
        logic                 too_long;
        logic                 bank;
    } lookup_req_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE_RD,
        B_PROBE_CHK,
        B_CMP_RD,
        B_CMP_CHK,
        B_COPY_RD,
        B_COPY_WR,
        B_DONE
    } back_state_t;

    // FNV-1a step; the prime 2^40 + 0x1b3 is applied as shifts and adds
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        begin
            x = h ^ {56'd0, b};
            fnv_step = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                     + (x << 1) + x;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/sih_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read once per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/sih_front.sv
// Front end: hashes name bytes, buffers them in two banks, emits lookup requests.
// Depends on sih_pkg.
`default_nettype none

module sih_front
    import sih_pkg::*;
#(
    parameter int NAME_BYTES = 64,
    parameter int IDX_W      = 6,
    parameter int LEN_W      = 7
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    input  wire logic              in_empty,
    input  wire logic              busy_clear,
    input  wire logic              q_room,
    output logic                   push,
    output lookup_req_t            push_req,
    output logic                   pend_we,
    output logic      [IDX_W:0]    pend_waddr,
    output logic      [7:0]        pend_wdata
);

    logic [63:0]      hash_reg, hash_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             long_reg, long_next;
    logic             bank_reg, bank_next;
    logic             take;
    logic [63:0]      hash_fin;

    assign in_ready = !busy_clear && q_room;
    assign take     = in_valid && in_ready;

    // Fold the byte into the running state
    always_comb begin
        hash_next  = hash_reg;
        len_next   = len_reg;
        long_next  = long_reg;
        bank_next  = bank_reg;
        pend_we    = 1'b0;
        pend_waddr = {bank_reg, len_reg[IDX_W-1:0]};
        pend_wdata = in_byte;
        if (take && !in_empty) begin
            hash_next = fnv_step(hash_reg, in_byte);
            if (len_reg < LEN_W'(NAME_BYTES)) begin
                pend_we  = 1'b1;
                len_next = len_reg + 1'b1;
            end else begin
                long_next = 1'b1;
            end
        end
        hash_fin          = (hash_next == 64'd0) ? 64'd1 : hash_next;
        push              = take && in_last;
        push_req.hash     = hash_fin;
        push_req.len      = MAX_LEN_W'(len_next);
        push_req.too_long = long_next;
        push_req.bank     = bank_reg;
        if (push) begin
            hash_next = HASH_BASIS;
            len_next  = '0;
            long_next = 1'b0;
            bank_next = !bank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= HASH_BASIS;
            len_reg  <= '0;
            long_reg <= 1'b0;
            bank_reg <= 1'b0;
        end else begin
            hash_reg <= hash_next;
            len_reg  <= len_next;
            long_reg <= long_next;
            bank_reg <= bank_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sih_queue.sv
// Two-entry request queue between front end and lookup engine.
// Depends on sih_pkg.
`default_nettype none

module sih_queue
    import sih_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  lookup_req_t      push_req,
    input  wire logic        pop,
    output logic             head_valid,
    output lookup_req_t      head,
    output logic             room,
    output logic [1:0]       count
);

    lookup_req_t entry_reg [2];
    logic        rd_ptr_reg, wr_ptr_reg;
    logic [1:0]  count_reg;

    assign head_valid = count_reg != 2'd0;
    assign head       = entry_reg[rd_ptr_reg];
    assign room       = count_reg != 2'd2;
    assign count      = count_reg;

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

>>> rtl/sih_back.sv
// Lookup engine: clears the slot table, probes, compares, inserts, drives results.
// Depends on sih_pkg and sih_ram.
`default_nettype none

module sih_back
    import sih_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int IDX_W       = 6,
    parameter int LEN_W       = 7
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [ID_W-1:0]   max_entries,
    input  wire logic              req_valid,
    input  lookup_req_t            req,
    output logic                   pop,
    output logic                   busy_clear,
    output logic      [IDX_W:0]    pend_raddr,
    input  wire logic [7:0]        pend_rdata,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic      [ID_W-1:0]   res_id,
    output status_t                res_status
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int META_W = ID_W + 64 + LEN_W;

    back_state_t        state_reg, state_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SLOT_W-1:0]  probe_reg, probe_next;
    logic [SLOT_W-1:0]  clr_reg, clr_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ID_W-1:0]    count_reg, count_next;
    logic [ID_W-1:0]    id_reg, id_next;
    status_t            status_reg, status_next;

    logic                    meta_we;
    logic [SLOT_W-1:0]       meta_waddr;
    logic [META_W-1:0]       meta_wdata, meta_rdata;
    logic                    byte_we;
    logic [SLOT_W+IDX_W-1:0] byte_addr;
    logic [7:0]              byte_rdata;

    logic [ID_W-1:0]  m_id;
    logic [63:0]      m_hash;
    logic [LEN_W-1:0] m_len;
    logic [LEN_W-1:0] rlen;
    logic             slot_empty, can_insert, key_eq, len_zero, probe_last, idx_last;

    assign {m_id, m_hash, m_len} = meta_rdata;
    assign rlen       = req.len[LEN_W-1:0];
    assign slot_empty = m_id == '0;
    assign can_insert = count_reg < max_entries;
    assign key_eq     = (m_hash == req.hash) && (m_len == rlen);
    assign len_zero   = rlen == '0;
    assign probe_last = probe_reg == SLOT_W'(TABLE_SLOTS - 1);
    assign idx_last   = LEN_W'(idx_reg) == rlen - 1'b1;
    assign pend_raddr = {req.bank, idx_reg};
    assign byte_addr  = {slot_reg, idx_reg};
    assign busy_clear = state_reg == B_CLEAR;
    assign res_valid  = state_reg == B_DONE;
    assign res_id     = id_reg;
    assign res_status = status_reg;
    assign pop        = (state_reg == B_DONE) && res_ready;

    sih_ram #(.WIDTH(META_W), .DEPTH(TABLE_SLOTS)) u_meta (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (slot_reg),
        .rdata (meta_rdata)
    );

    sih_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS * (2 ** IDX_W))) u_bytes (
        .aclk  (aclk),
        .we    (byte_we),
        .waddr (byte_addr),
        .wdata (pend_rdata),
        .raddr (byte_addr),
        .rdata (byte_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
                if (clr_reg == SLOT_W'(TABLE_SLOTS - 1)) state_next = B_IDLE;
            B_IDLE:
                if (req_valid) state_next = req.too_long ? B_DONE : B_PROBE_RD;
            B_PROBE_RD:
                state_next = B_PROBE_CHK;
            B_PROBE_CHK: begin
                priority if (slot_empty) begin
                    state_next = (can_insert && !len_zero) ? B_COPY_RD : B_DONE;
                end else if (key_eq) begin
                    state_next = len_zero ? B_DONE : B_CMP_RD;
                end else begin
                    state_next = probe_last ? B_DONE : B_PROBE_RD;
                end
            end
            B_CMP_RD:
                state_next = B_CMP_CHK;
            B_CMP_CHK: begin
                priority if (pend_rdata != byte_rdata) begin
                    state_next = probe_last ? B_DONE : B_PROBE_RD;
                end else if (idx_last) begin
                    state_next = B_DONE;
                end else begin
                    state_next = B_CMP_RD;
                end
            end
            B_COPY_RD:
                state_next = B_COPY_WR;
            B_COPY_WR:
                state_next = idx_last ? B_DONE : B_COPY_RD;
            B_DONE:
                if (res_ready) state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // Datapath controls and result
    always_comb begin
        slot_next   = slot_reg;
        probe_next  = probe_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        id_next     = id_reg;
        status_next = status_reg;
        meta_we     = 1'b0;
        meta_waddr  = slot_reg;
        meta_wdata  = {count_reg + 1'b1, req.hash, rlen};
        byte_we     = 1'b0;
        unique case (state_reg)
            B_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = '0;
                clr_next   = clr_reg + 1'b1;
            end
            B_IDLE: begin
                slot_next   = req.hash[SLOT_W-1:0];
                probe_next  = '0;
                idx_next    = '0;
                id_next     = '0;
                status_next = ST_LONG;
            end
            B_PROBE_RD: begin
                idx_next = '0;
            end
            B_PROBE_CHK: begin
                priority if (slot_empty) begin
                    if (can_insert) begin
                        meta_we     = 1'b1;
                        count_next  = count_reg + 1'b1;
                        id_next     = count_reg + 1'b1;
                        status_next = ST_NEW;
                    end else begin
                        id_next     = '0;
                        status_next = ST_FULL;
                    end
                end else if (key_eq) begin
                    id_next     = m_id;
                    status_next = ST_FOUND;
                end else begin
                    slot_next   = slot_reg + 1'b1;
                    probe_next  = probe_reg + 1'b1;
                    id_next     = '0;
                    status_next = ST_FULL;
                end
            end
            B_CMP_CHK: begin
                priority if (pend_rdata != byte_rdata) begin
                    slot_next   = slot_reg + 1'b1;
                    probe_next  = probe_reg + 1'b1;
                    id_next     = '0;
                    status_next = ST_FULL;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            B_COPY_WR: begin
                byte_we  = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            B_CMP_RD, B_COPY_RD, B_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        probe_reg  <= probe_next;
        idx_reg    <= idx_next;
        id_reg     <= id_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

>>> rtl/string_intern_hash_table.sv
// Name intern table: takes a name one byte per transaction (s_tlast marks the
// final byte, s_tuser a transaction that carries no byte), keeps a 64-bit
// FNV-1a hash and returns one result per name: identifier and status (found,
// new, full, too long). Bytes are taken at one per cycle while the request
// queue has room; the two-entry queue lets the next names stream in while a
// lookup runs. A lookup picks up the request, probes slots, compares or
// copies stored bytes and hands out the result, each step paced by the
// registered reads of the slot and byte RAMs; the result then waits for
// m_tready. After reset the slot table is swept clear, during which no
// transaction is taken. TABLE_SLOTS must be a power of two.
// Depends on sih_pkg, sih_front, sih_queue, sih_back, sih_ram.
`default_nettype none

module string_intern_hash_table
    import sih_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int NAME_BYTES  = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [ID_W-1:0]  cfg_wdata,    // max_entries
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,      // [7:0] name_byte
    input  wire logic             s_tlast,      // is_last
    input  wire logic             s_tuser,      // empty_name
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [15:0]      m_tdata       // [9:0] identifier, [11:10] status
);

    localparam int IDX_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int LEN_W = $clog2(NAME_BYTES + 1);

    logic [ID_W-1:0] max_reg;
    logic            push, pop, q_room, q_valid, busy_clear;
    logic [1:0]      q_count;
    lookup_req_t     push_req, head;
    logic            pend_we;
    logic [IDX_W:0]  pend_waddr, pend_raddr;
    logic [7:0]      pend_wdata, pend_rdata;
    logic [ID_W-1:0] res_id;
    status_t         res_status;

    // Hold the entry limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= ID_W'(512);
        end else if (cfg_we) begin
            max_reg <= cfg_wdata;
        end
    end

    sih_front #(.NAME_BYTES(NAME_BYTES), .IDX_W(IDX_W), .LEN_W(LEN_W)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .in_empty   (s_tuser),
        .busy_clear (busy_clear),
        .q_room     (q_room),
        .push       (push),
        .push_req   (push_req),
        .pend_we    (pend_we),
        .pend_waddr (pend_waddr),
        .pend_wdata (pend_wdata)
    );

    sih_ram #(.WIDTH(8), .DEPTH(2 * (2 ** IDX_W))) u_pending (
        .aclk  (aclk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    sih_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_req   (push_req),
        .pop        (pop),
        .head_valid (q_valid),
        .head       (head),
        .room       (q_room),
        .count      (q_count)
    );

    sih_back #(.TABLE_SLOTS(TABLE_SLOTS), .IDX_W(IDX_W), .LEN_W(LEN_W)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .max_entries (max_reg),
        .req_valid   (q_valid),
        .req         (head),
        .pop         (pop),
        .busy_clear  (busy_clear),
        .pend_raddr  (pend_raddr),
        .pend_rdata  (pend_rdata),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_id      (res_id),
        .res_status  (res_status)
    );

    assign m_tdata = {4'd0, res_status, res_id};

    // Nothing is taken while the slot table is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn) busy_clear |-> !s_tready)
        else $error("transaction taken during clearing pass");

    // Queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn) q_count != 2'd3)
        else $error("request queue overflow");

    // A result is only offered for a queued request
    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> q_valid)
        else $error("result without request");

    // Errors carry identifier zero, successes a non-zero one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((res_status == ST_FULL || res_status == ST_LONG) == (res_id == '0)))
        else $error("identifier does not match status");

endmodule

`default_nettype wire

>>> tb/sih_checker.sv
// Scoreboard for the string intern table: watches the byte and result streams,
// keeps its own copy of the slot table and compares every result transaction.
// Depends on sih_pkg for the status codes, ID_W and HASH_BASIS.
`timescale 1ns / 100ps

module sih_checker
    import sih_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_we,
    input  wire logic [ID_W-1:0] cfg_wdata,
    input  wire logic            s_tvalid,
    input  wire logic            s_tready,
    input  wire logic [7:0]      s_tdata,
    input  wire logic            s_tlast,
    input  wire logic            s_tuser,
    input  wire logic            m_tvalid,
    input  wire logic            m_tready,
    input  wire logic [15:0]     m_tdata,
    output int                   errors,
    output int                   pending
);

    localparam int SLOTS    = 1024;
    localparam int NAME_MAX = 64;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

    typedef struct packed {
        logic [ID_W-1:0] id;
        status_t         status;
    } intern_result_t;

    intern_result_t expected_ids[$];

    // Own copy of the name accumulator and slot table
    logic [ID_W-1:0] limit_entries;
    logic [ID_W-1:0] entries;
    logic [63:0]     name_hash;
    int              buf_len;
    bit              name_long;
    logic [7:0]      name_buf [NAME_MAX];
    logic [ID_W-1:0] slot_id  [SLOTS];
    logic [63:0]     slot_hsh [SLOTS];
    int              slot_len [SLOTS];
    logic [7:0]      slot_dat [SLOTS][NAME_MAX];

    function automatic bit slot_holds_name(input int s, input logic [63:0] h);
        bit same;
        same = (slot_hsh[s] == h) && (slot_len[s] == buf_len);
        for (int i = 0; i < buf_len && same; i++)
            if (slot_dat[s][i] != name_buf[i]) same = 1'b0;
        return same;
    endfunction

    // Probe the table for the gathered name, inserting it if there is room
    function automatic intern_result_t intern_name();
        intern_result_t r;
        logic [63:0] h;
        int s;
        r.id = '0;
        r.status = ST_FULL;
        h = (name_hash == 64'd0) ? 64'd1 : name_hash;
        s = int'(h[9:0]);
        for (int n = 0; n < SLOTS; n++) begin
            if (slot_id[s] == '0) begin
                if (entries >= limit_entries) return r;
                entries = entries + 1'b1;
                slot_id[s] = entries;
                slot_hsh[s] = h;
                slot_len[s] = buf_len;
                for (int i = 0; i < buf_len; i++) slot_dat[s][i] = name_buf[i];
                r.id = entries;
                r.status = ST_NEW;
                return r;
            end
            if (slot_holds_name(s, h)) begin
                r.id = slot_id[s];
                r.status = ST_FOUND;
                return r;
            end
            s = (s + 1) % SLOTS;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        intern_result_t want, got;
        int bad;
        bad = 0;
        if (!aresetn) begin
            limit_entries = 10'd512;
            entries = '0;
            name_hash = HASH_BASIS;
            buf_len = 0;
            name_long = 1'b0;
            for (int s = 0; s < SLOTS; s++) slot_id[s] = '0;
            expected_ids.delete();
            errors <= 0;
        end else begin
            if (cfg_we) limit_entries = cfg_wdata;
            // Compare the result transaction with the oldest expectation
            if (m_tvalid && m_tready) begin
                got.id = m_tdata[9:0];
                got.status = status_t'(m_tdata[11:10]);
                if (expected_ids.size() == 0) begin
                    $display("%0t: unexpected result id=%0d status=%0d",
                             $time, got.id, got.status);
                    bad++;
                end else begin
                    want = expected_ids.pop_front();
                    if (want.id != got.id) begin
                        $display("%0t: identifier expected %0d actual %0d",
                                 $time, want.id, got.id);
                        bad++;
                    end
                    if (want.status != got.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        bad++;
                    end
                end
            end
            // Fold an accepted byte in; look the name up on the last one
            if (s_tvalid && s_tready) begin
                if (!s_tuser) begin
                    name_hash = (name_hash ^ {56'd0, s_tdata}) * FNV_PRIME;
                    if (buf_len < NAME_MAX) begin
                        name_buf[buf_len] = s_tdata;
                        buf_len++;
                    end else begin
                        name_long = 1'b1;
                    end
                end
                if (s_tlast) begin
                    if (name_long) begin
                        want.id = '0;
                        want.status = ST_LONG;
                    end else begin
                        want = intern_name();
                    end
                    expected_ids.push_back(want);
                    name_hash = HASH_BASIS;
                    buf_len = 0;
                    name_long = 1'b0;
                end
            end
            if (bad != 0) errors <= errors + bad;
        end
        pending <= expected_ids.size();
    end

endmodule

>>> tb/tb_string_intern_hash_table.sv
// Top of the string intern table testbench: clock, reset, name stimulus,
// receiver back-pressure and the verdict. Depends on sih_pkg, the block
// and sih_checker.
`timescale 1ns / 100ps

module tb_string_intern_hash_table;
    import sih_pkg::*;

    localparam int STALL_LIMIT = 40000;
    localparam int POOL_SIZE   = 32;

    logic            aclk;
    logic            aresetn;
    logic            cfg_we;
    logic [ID_W-1:0] cfg_wdata;
    logic            s_tvalid;
    logic            s_tready;
    logic [7:0]      s_tdata;
    logic            s_tlast;
    logic            s_tuser;
    logic            m_tvalid;
    logic            m_tready;
    logic [15:0]     m_tdata;
    int              errors;
    int              pending;

    bit              idle_on;
    bit              hold_req;
    int              items_sent;
    int              quiet_cycles;
    logic [7:0]      name_buf [80];
    int              cur_len;
    logic [7:0]      pool_dat [POOL_SIZE][64];
    int              pool_len [POOL_SIZE];
    int              pool_fill;

    string_intern_hash_table dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    sih_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Receiver: random idling, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 8);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one byte transaction and hold it until taken
    task automatic send_item(input logic [7:0] b, input bit last, input bit empty);
        while (idle_on && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= empty;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Send name_buf; a zero length goes out as an empty-name transaction
    task automatic send_name();
        if (cur_len == 0) begin
            send_item(8'($urandom_range(255)), 1'b1, 1'b1);
        end else begin
            for (int i = 0; i < cur_len; i++)
                send_item(name_buf[i], i == cur_len - 1, 1'b0);
        end
    endtask

    task automatic make_name(input int len);
        cur_len = len;
        for (int i = 0; i < len; i++) name_buf[i] = 8'($urandom_range(255));
        if (len > 0 && len <= 64 && pool_fill < POOL_SIZE) begin
            for (int i = 0; i < len; i++) pool_dat[pool_fill][i] = name_buf[i];
            pool_len[pool_fill] = len;
            pool_fill++;
        end
    endtask

    task automatic reuse_name();
        int k;
        k = $urandom_range(pool_fill - 1);
        cur_len = pool_len[k];
        for (int i = 0; i < cur_len; i++) name_buf[i] = pool_dat[k][i];
    endtask

    // Drain all results, let the engine settle, then write the limit
    task automatic set_limit(input logic [ID_W-1:0] v);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (50) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input int n_items);
        int r, stop;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            r = $urandom_range(99);
            if (r < 35) begin
                reuse_name();
                send_name();
            end else if (r < 80) begin
                make_name($urandom_range(1, 8));
                send_name();
            end else if (r < 85) begin
                make_name($urandom_range(20, 64));
                send_name();
            end else if (r < 87) begin
                make_name($urandom_range(65, 70));
                send_name();
            end else if (r < 91) begin
                cur_len = 0;
                send_name();
            end else if (r < 95) begin
                // Stray empty flag in mid name: no byte added
                make_name($urandom_range(1, 4));
                send_item(name_buf[0], 1'b0, 1'b0);
                send_item(8'($urandom_range(255)), 1'b0, 1'b1);
                for (int i = 1; i < cur_len; i++)
                    send_item(name_buf[i], i == cur_len - 1, 1'b0);
                if (cur_len == 1) send_item(8'h00, 1'b1, 1'b1);
            end else begin
                // Name closed by an empty-flagged last transaction
                make_name($urandom_range(1, 5));
                for (int i = 0; i < cur_len; i++) send_item(name_buf[i], 1'b0, 1'b0);
                send_item(8'($urandom_range(255)), 1'b1, 1'b1);
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = 1'b0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        items_sent = 0;
        pool_fill = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: byte extremes, repeats, empty names, length limits
        cur_len = 1; name_buf[0] = 8'h00; send_name();
        name_buf[0] = 8'hFF; send_name();
        name_buf[0] = 8'h00; send_name();
        cur_len = 0; send_name();
        send_name();
        send_item(8'hA5, 1'b0, 1'b1);
        make_name(64); send_name();
        reuse_name(); cur_len = pool_len[pool_fill - 1];
        for (int i = 0; i < 64; i++) name_buf[i] = pool_dat[pool_fill - 1][i];
        send_name();
        make_name(65); send_name();
        cur_len = 2; name_buf[0] = 8'h55; name_buf[1] = 8'hAA;
        send_item(8'h55, 1'b0, 1'b0); send_item(8'hAA, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_name();

        // Limit at its low end: one more insert fits, then the table is full
        set_limit(10'd6);
        make_name(3); send_name();
        make_name(3); send_name();
        reuse_name(); send_name();
        set_limit(10'd0);
        make_name(2); send_name();
        reuse_name(); send_name();

        // Random phases at several limits
        set_limit(10'd1023);
        random_phase(200);
        idle_on = 1'b0;
        random_phase(100);
        idle_on = 1'b1;
        hold_req = 1'b1;
        random_phase(120);
        set_limit(10'd1);
        random_phase(80);
        set_limit(10'd1023);
        random_phase(130);
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/sih_pkg.sv
rtl/sih_ram.sv
rtl/sih_front.sv
rtl/sih_queue.sv
rtl/sih_back.sv
rtl/string_intern_hash_table.sv
tb/sih_checker.sv
tb/tb_string_intern_hash_table.sv
